FILE: src/closed_tour_length_macros.svh
// ----------------------------------------------------------------------------
// closed tour length assertion macros
// shared property templates, sampled on clk_i and disabled while rst_ni is low
// ----------------------------------------------------------------------------
`ifndef CLOSED_TOUR_LENGTH_MACROS_SVH
`define CLOSED_TOUR_LENGTH_MACROS_SVH

// antecedent implies consequent in the same cycle
`define CTL_ASSERT_IMPL(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// antecedent implies consequent in the next cycle
`define CTL_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: src/ctl_pkg.sv
// ----------------------------------------------------------------------------
// ctl_pkg
// widths, command and status types of the closed tour length block
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package ctl_pkg;

  // coordinate width actually used; upper field bits are ignored
  localparam int unsigned COORD_WIDTH = 32;

  localparam int unsigned FIELD_W = 32;
  localparam int unsigned TOTAL_W = 63;
  localparam int unsigned DIFF_W  = COORD_WIDTH + 1;
  localparam int unsigned MAG_W   = COORD_WIDTH;
  localparam int unsigned SQ_W    = 2 * MAG_W;
  localparam int unsigned RAD_W   = 2 * COORD_WIDTH + 2;
  localparam int unsigned ROOT_W  = COORD_WIDTH + 1;
  localparam int unsigned REM_W   = COORD_WIDTH + 2;
  localparam int unsigned ITER    = RAD_W / 2;
  localparam int unsigned CNT_W   = $clog2(ITER);

  localparam logic [TOTAL_W-1:0] TOTAL_MAX = {TOTAL_W{1'b1}};

  typedef struct packed {
    logic ld_point;    // capture the accepted city
    logic start_tour;  // city opens a new tour
    logic diff_en;     // form absolute differences
    logic diff_close;  // difference against the first city
    logic sq_en;       // register the squares
    logic root_init;   // load the radicand
    logic root_step;   // one digit of the square root
    logic acc_en;      // add the edge to the total
    logic emit;        // load the result word
  } ctl_cmd_t;

  typedef struct packed {
    logic out_busy;    // result word waiting and not taken this cycle
  } ctl_status_t;

endpackage

FILE: src/ctl_stream_if.sv
// ----------------------------------------------------------------------------
// ctl stream interfaces
// valid/ready channels for city words and result words
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

interface ctl_in_if;
  logic                               valid;
  logic                               ready;
  logic signed [ctl_pkg::FIELD_W-1:0] x_coord;
  logic signed [ctl_pkg::FIELD_W-1:0] y_coord;
  logic                               last_city;

  modport source (output valid, output x_coord, output y_coord, output last_city,
                  input ready);
  modport sink   (input valid, input x_coord, input y_coord, input last_city,
                  output ready);
endinterface

interface ctl_out_if;
  logic                        valid;
  logic                        ready;
  logic [ctl_pkg::TOTAL_W-1:0] tour_length;
  logic                        saturated;

  modport source (output valid, output tour_length, output saturated, input ready);
  modport sink   (input valid, input tour_length, input saturated, output ready);
endinterface

FILE: src/ctl_datapath.sv
// ----------------------------------------------------------------------------
// ctl_datapath
// point registers, difference and square stage, digit-serial square root,
// saturating accumulator and result word register
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "closed_tour_length_macros.svh"

module ctl_datapath (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic signed [ctl_pkg::FIELD_W-1:0] x_coord_i,
  input  logic signed [ctl_pkg::FIELD_W-1:0] y_coord_i,
  input  ctl_pkg::ctl_cmd_t                  cmd_i,
  output ctl_pkg::ctl_status_t               status_o,
  input  logic                               out_ready_i,
  output logic                               out_valid_o,
  output logic [ctl_pkg::TOTAL_W-1:0]        tour_length_o,
  output logic                               saturated_o
);

  logic signed [ctl_pkg::COORD_WIDTH-1:0] in_x, in_y;
  logic signed [ctl_pkg::COORD_WIDTH-1:0] cur_x_q, cur_y_q;
  logic signed [ctl_pkg::COORD_WIDTH-1:0] first_x_q, first_y_q;
  logic signed [ctl_pkg::COORD_WIDTH-1:0] prev_x_q, prev_y_q;
  logic signed [ctl_pkg::COORD_WIDTH-1:0] ref_x, ref_y;
  logic signed [ctl_pkg::DIFF_W-1:0]      dx, dy, ndx, ndy;
  logic [ctl_pkg::MAG_W-1:0]              mx_d, my_d, mx_q, my_q;
  logic [ctl_pkg::SQ_W-1:0]               sx_d, sy_d, sx_q, sy_q;
  logic [ctl_pkg::RAD_W-1:0]              rad_q;
  logic [ctl_pkg::REM_W-1:0]              rem_q, rem_d;
  logic [ctl_pkg::ROOT_W-1:0]             root_q;
  logic [ctl_pkg::REM_W+1:0]              rem_sh, trial, rem_sub;
  logic                                   digit;
  logic [ctl_pkg::TOTAL_W:0]              acc_sum;
  logic                                   acc_sat;
  logic [ctl_pkg::TOTAL_W-1:0]            total_q;
  logic                                   ovf_q;
  logic                                   out_valid_q;
  logic [ctl_pkg::TOTAL_W-1:0]            out_len_q;
  logic                                   out_sat_q;

  // only the low coordinate bits count, taken as two's complement
  assign in_x = x_coord_i[ctl_pkg::COORD_WIDTH-1:0];
  assign in_y = y_coord_i[ctl_pkg::COORD_WIDTH-1:0];

  // absolute differences
  assign ref_x = cmd_i.diff_close ? first_x_q : prev_x_q;
  assign ref_y = cmd_i.diff_close ? first_y_q : prev_y_q;
  assign dx    = ctl_pkg::DIFF_W'(cur_x_q) - ctl_pkg::DIFF_W'(ref_x);
  assign dy    = ctl_pkg::DIFF_W'(cur_y_q) - ctl_pkg::DIFF_W'(ref_y);
  assign ndx   = -dx;
  assign ndy   = -dy;
  assign mx_d  = dx[ctl_pkg::DIFF_W-1] ? ndx[ctl_pkg::MAG_W-1:0] : dx[ctl_pkg::MAG_W-1:0];
  assign my_d  = dy[ctl_pkg::DIFF_W-1] ? ndy[ctl_pkg::MAG_W-1:0] : dy[ctl_pkg::MAG_W-1:0];

  assign sx_d  = mx_q * mx_q;
  assign sy_d  = my_q * my_q;

  // restoring square root, two radicand bits per step
  assign rem_sh  = {rem_q, rad_q[ctl_pkg::RAD_W-1 -: 2]};
  assign trial   = {1'b0, root_q, 2'b01};
  assign digit   = (rem_sh >= trial);
  assign rem_sub = rem_sh - trial;
  assign rem_d   = digit ? rem_sub[ctl_pkg::REM_W-1:0] : rem_sh[ctl_pkg::REM_W-1:0];

  // saturating add of the finished edge
  assign acc_sum = {1'b0, total_q} + (ctl_pkg::TOTAL_W + 1)'(root_q);
  assign acc_sat = (acc_sum >= {1'b0, ctl_pkg::TOTAL_MAX});

  always_ff @(posedge clk_i) begin
    if (cmd_i.ld_point) begin
      cur_x_q <= in_x;
      cur_y_q <= in_y;
    end
    if (cmd_i.ld_point && cmd_i.start_tour) begin
      first_x_q <= in_x;
      first_y_q <= in_y;
      prev_x_q  <= in_x;
      prev_y_q  <= in_y;
    end else if (cmd_i.acc_en) begin
      prev_x_q  <= cur_x_q;
      prev_y_q  <= cur_y_q;
    end
    if (cmd_i.diff_en) begin
      mx_q <= mx_d;
      my_q <= my_d;
    end
    if (cmd_i.sq_en) begin
      sx_q <= sx_d;
      sy_q <= sy_d;
    end
    if (cmd_i.root_init) begin
      rad_q  <= ctl_pkg::RAD_W'(sx_q) + ctl_pkg::RAD_W'(sy_q);
      rem_q  <= '0;
      root_q <= '0;
    end else if (cmd_i.root_step) begin
      rad_q  <= {rad_q[ctl_pkg::RAD_W-3:0], 2'b00};
      rem_q  <= rem_d;
      root_q <= {root_q[ctl_pkg::ROOT_W-2:0], digit};
    end
    if (cmd_i.emit) begin
      out_len_q <= total_q;
      out_sat_q <= ovf_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      total_q     <= '0;
      ovf_q       <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (cmd_i.ld_point && cmd_i.start_tour) begin
        total_q <= '0;
        ovf_q   <= 1'b0;
      end else if (cmd_i.acc_en) begin
        total_q <= acc_sat ? ctl_pkg::TOTAL_MAX : acc_sum[ctl_pkg::TOTAL_W-1:0];
        ovf_q   <= ovf_q | acc_sat;
      end
      if (cmd_i.emit) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  assign status_o.out_busy = out_valid_q && !out_ready_i;
  assign out_valid_o       = out_valid_q;
  assign tour_length_o     = out_len_q;
  assign saturated_o       = out_sat_q;

  `CTL_ASSERT_IMPL(a_ovf_pins_total, ovf_q, total_q == ctl_pkg::TOTAL_MAX, "total not at max")
  `CTL_ASSERT_IMPL(a_emit_no_overwrite, cmd_i.emit, !out_valid_q || out_ready_i, "word lost")
  `CTL_ASSERT_NEXT(a_valid_held, out_valid_q && !out_ready_i, out_valid_q, "word dropped")

endmodule

FILE: src/ctl_controller.sv
// ----------------------------------------------------------------------------
// ctl_controller
// sequencer for city intake, edge computation, square root digits and emit
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "closed_tour_length_macros.svh"

module ctl_controller (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  input  logic                 in_last_i,
  output logic                 in_ready_o,
  input  ctl_pkg::ctl_status_t status_i,
  output ctl_pkg::ctl_cmd_t    cmd_o
);

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_DIFF,
    ST_SQR,
    ST_INIT,
    ST_ROOT,
    ST_ACC,
    ST_EMIT
  } state_e;

  state_e                    state_q;
  logic [ctl_pkg::CNT_W-1:0] cnt_q;
  logic                      have_first_q;
  logic                      last_q;
  logic                      close_q;
  logic                      accept;

  assign in_ready_o = (state_q == ST_IDLE);
  assign accept     = in_valid_i && in_ready_o;

  always_comb begin
    cmd_o            = '0;
    cmd_o.diff_close = close_q;
    case (state_q)
      ST_IDLE: begin
        cmd_o.ld_point   = accept;
        cmd_o.start_tour = accept && !have_first_q;
      end
      ST_DIFF: cmd_o.diff_en   = 1'b1;
      ST_SQR:  cmd_o.sq_en     = 1'b1;
      ST_INIT: cmd_o.root_init = 1'b1;
      ST_ROOT: cmd_o.root_step = 1'b1;
      ST_ACC:  cmd_o.acc_en    = 1'b1;
      ST_EMIT: cmd_o.emit      = !status_i.out_busy;
      default: cmd_o = '0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= ST_IDLE;
      cnt_q        <= '0;
      have_first_q <= 1'b0;
      last_q       <= 1'b0;
      close_q      <= 1'b0;
    end else begin
      case (state_q)
        ST_IDLE: begin
          if (accept) begin
            have_first_q <= 1'b1;
            last_q       <= in_last_i;
            if (have_first_q) begin
              close_q <= 1'b0;
              state_q <= ST_DIFF;
            end else if (in_last_i) begin
              // single city so far: only the closing edge remains
              close_q <= 1'b1;
              state_q <= ST_DIFF;
            end
          end
        end
        ST_DIFF: state_q <= ST_SQR;
        ST_SQR:  state_q <= ST_INIT;
        ST_INIT: begin
          cnt_q   <= '0;
          state_q <= ST_ROOT;
        end
        ST_ROOT: begin
          if (cnt_q == ctl_pkg::CNT_W'(ctl_pkg::ITER - 1)) begin
            state_q <= ST_ACC;
          end else begin
            cnt_q <= cnt_q + 1'b1;
          end
        end
        ST_ACC: begin
          if (close_q) begin
            state_q <= ST_EMIT;
          end else if (last_q) begin
            close_q <= 1'b1;
            state_q <= ST_DIFF;
          end else begin
            state_q <= ST_IDLE;
          end
        end
        ST_EMIT: begin
          if (!status_i.out_busy) begin
            have_first_q <= 1'b0;
            last_q       <= 1'b0;
            close_q      <= 1'b0;
            state_q      <= ST_IDLE;
          end
        end
        default: state_q <= ST_IDLE;
      endcase
    end
  end

  `CTL_ASSERT_NEXT(a_close_then_emit, state_q == ST_ACC && close_q, state_q == ST_EMIT, "no emit")
  `CTL_ASSERT_NEXT(a_last_then_close, state_q == ST_ACC && !close_q && last_q,
                   state_q == ST_DIFF && close_q, "closing edge skipped")
  `CTL_ASSERT_IMPL(a_cnt_bound, state_q == ST_ROOT,
                   cnt_q <= ctl_pkg::CNT_W'(ctl_pkg::ITER - 1), "root digit count out of range")

endmodule

FILE: src/closed_tour_length.sv
// ----------------------------------------------------------------------------
// closed_tour_length
// Euclidean length of a closed tour of Q16.16 cities, emitted per tour
// ----------------------------------------------------------------------------
// Usage: in_i takes one city word per handshake (x_coord, y_coord in signed
// Q16.16, last_city on the final city). out_o gives one result word per tour:
// tour_length in unsigned Q47.16, held at 2^63-1 with saturated set on overflow.
// A tour of one city gives zero.
// Each edge runs through difference, squares, radicand load, COORD_WIDTH + 1
// square root digits and accumulate, one digit at a time. The first city of a
// tour only loads the point registers, a middle city adds one edge, and the
// last city adds its edge and then the closing edge (only the closing edge for
// a one-city tour), after which the result word is loaded. One city is in work
// at a time; in_i.ready is high only between cities.
// Stall: the result word sits in an output register, so the next tour's
// cities are taken while it waits; only a second result stalls until the
// first is taken.
// Reset: rst_ni clears the tour state and drops out_o.valid; the next city
// opens a new tour.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module closed_tour_length (
  input  logic  clk_i,
  input  logic  rst_ni,
  ctl_in_if.sink     in_i,
  ctl_out_if.source  out_o
);

  ctl_pkg::ctl_cmd_t    cmd;
  ctl_pkg::ctl_status_t status;

  ctl_controller u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_i.valid),
    .in_last_i  (in_i.last_city),
    .in_ready_o (in_i.ready),
    .status_i   (status),
    .cmd_o      (cmd)
  );

  ctl_datapath u_dp (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .x_coord_i     (in_i.x_coord),
    .y_coord_i     (in_i.y_coord),
    .cmd_i         (cmd),
    .status_o      (status),
    .out_ready_i   (out_o.ready),
    .out_valid_o   (out_o.valid),
    .tour_length_o (out_o.tour_length),
    .saturated_o   (out_o.saturated)
  );

endmodule

FILE: tb/tb_closed_tour_length.sv
// ----------------------------------------------------------------------------
// tb_closed_tour_length
// Sends tours of Q16.16 cities through closed_tour_length under several idle
// and stall mixes, predicts each closed tour length and saturation flag
// alongside, and checks every result word against the oldest prediction.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_closed_tour_length;

  localparam int unsigned CLK_PERIOD     = 10;
  localparam int unsigned HOLD_CYCLES    = 600;
  localparam int unsigned WATCHDOG_LIMIT = 5000;
  localparam int unsigned DRAIN_CYCLES   = 100;

  localparam logic [ctl_pkg::FIELD_W-1:0] COORD_MIN = 32'h8000_0000;
  localparam logic [ctl_pkg::FIELD_W-1:0] COORD_MAX = 32'h7fff_ffff;
  localparam logic [ctl_pkg::FIELD_W-1:0] Q_ONE     = 32'h0001_0000;

  typedef struct {
    logic [ctl_pkg::TOTAL_W-1:0] length;
    logic                        sat;
  } tour_result_t;

  logic clk = 1'b0;
  logic rst_n;

  ctl_in_if  city_bus ();
  ctl_out_if tour_bus ();

  closed_tour_length dut (
    .clk_i  (clk),
    .rst_ni (rst_n),
    .in_i   (city_bus),
    .out_o  (tour_bus)
  );

  always #(CLK_PERIOD / 2) clk = ~clk;

  tour_result_t pending_tours[$];
  int unsigned  errors          = 0;
  int unsigned  city_idle_pct   = 0;
  int unsigned  result_stall_pct = 0;
  int unsigned  holds_requested = 0;

  // tour tracker
  longint                      orig_x, orig_y, prev_x, prev_y;
  logic                        tour_open;
  logic [ctl_pkg::TOTAL_W-1:0] length_acc;
  logic                        length_sat;

  function automatic longint coord_value(logic [ctl_pkg::FIELD_W-1:0] raw);
    longint v;
    v = longint'(raw[ctl_pkg::COORD_WIDTH-1:0]);
    if (raw[ctl_pkg::COORD_WIDTH-1]) v -= longint'(1) << ctl_pkg::COORD_WIDTH;
    return v;
  endfunction

  // floor of the euclidean distance, exact q34.32 radicand, bitwise root
  function automatic logic [ctl_pkg::ROOT_W-1:0] edge_length(
      input longint ax, input longint ay, input longint bx, input longint by);
    longint                     dx, dy;
    logic [ctl_pkg::RAD_W-1:0]  mx, my, radicand, sq;
    logic [ctl_pkg::ROOT_W-1:0] root, trial;
    dx = ax - bx;
    dy = ay - by;
    mx = (dx < 0) ? ctl_pkg::RAD_W'(-dx) : ctl_pkg::RAD_W'(dx);
    my = (dy < 0) ? ctl_pkg::RAD_W'(-dy) : ctl_pkg::RAD_W'(dy);
    radicand = mx * mx + my * my;
    root = '0;
    for (int b = ctl_pkg::ROOT_W - 1; b >= 0; b--) begin
      trial = root | (ctl_pkg::ROOT_W'(1) << b);
      sq = trial * trial;
      if (sq <= radicand) root = trial;
    end
    return root;
  endfunction

  function automatic void add_to_tour(logic [ctl_pkg::ROOT_W-1:0] d);
    logic [ctl_pkg::TOTAL_W:0] s;
    s = {1'b0, length_acc} + (ctl_pkg::TOTAL_W + 1)'(d);
    if (s >= {1'b0, ctl_pkg::TOTAL_MAX}) begin
      length_acc = ctl_pkg::TOTAL_MAX;
      length_sat = 1'b1;
    end else begin
      length_acc = s[ctl_pkg::TOTAL_W-1:0];
    end
  endfunction

  function automatic void clear_tour();
    orig_x = 0; orig_y = 0; prev_x = 0; prev_y = 0;
    tour_open = 1'b0;
    length_acc = '0;
    length_sat = 1'b0;
  endfunction

  function automatic void track_city(logic [ctl_pkg::FIELD_W-1:0] xr,
                                     logic [ctl_pkg::FIELD_W-1:0] yr, logic last);
    longint       x, y;
    tour_result_t r;
    x = coord_value(xr);
    y = coord_value(yr);
    if (!tour_open) begin
      orig_x = x;
      orig_y = y;
      tour_open = 1'b1;
      length_acc = '0;
      length_sat = 1'b0;
    end else begin
      add_to_tour(edge_length(x, y, prev_x, prev_y));
    end
    prev_x = x;
    prev_y = y;
    if (last) begin
      add_to_tour(edge_length(x, y, orig_x, orig_y));
      r.length = length_acc;
      r.sat    = length_sat;
      pending_tours = {pending_tours, r};
      clear_tour();
    end
  endfunction

  // one city word; valid stays up after the handshake unless the next call idles
  task automatic send_city(input logic [ctl_pkg::FIELD_W-1:0] x,
                           input logic [ctl_pkg::FIELD_W-1:0] y, input logic last);
    while ($urandom_range(99) < city_idle_pct) begin
      city_bus.valid <= 1'b0;
      @(posedge clk);
    end
    city_bus.valid     <= 1'b1;
    city_bus.x_coord   <= x;
    city_bus.y_coord   <= y;
    city_bus.last_city <= last;
    do @(posedge clk); while (!city_bus.ready);
    track_city(x, y, last);
  endtask

  task automatic wait_drained();
    city_bus.valid <= 1'b0;
    while (pending_tours.size() != 0) @(posedge clk);
  endtask

  function automatic logic [ctl_pkg::FIELD_W-1:0] rand_coord();
    case ($urandom_range(7))
      0: return COORD_MIN;
      1: return COORD_MAX;
      2: return ctl_pkg::FIELD_W'($urandom_range(0, 1 << 18)) - (ctl_pkg::FIELD_W'(1) << 17);
      3: return ctl_pkg::FIELD_W'($urandom_range(0, 2)) - ctl_pkg::FIELD_W'(1);
      default: return ctl_pkg::FIELD_W'($urandom);
    endcase
  endfunction

  task automatic test_directed();
    city_idle_pct = 0;
    result_stall_pct = 0;
    // single-city tours close on themselves
    send_city(COORD_MAX, COORD_MIN, 1'b1);
    send_city('0, '0, 1'b1);
    // 3-4-5 triangle
    send_city('0, '0, 1'b0);
    send_city(3 * Q_ONE, '0, 1'b0);
    send_city(3 * Q_ONE, 4 * Q_ONE, 1'b1);
    // opposite corners, largest radicand
    send_city(COORD_MIN, COORD_MIN, 1'b0);
    send_city(COORD_MAX, COORD_MAX, 1'b1);
    // square over the whole plane
    send_city(COORD_MIN, COORD_MIN, 1'b0);
    send_city(COORD_MAX, COORD_MIN, 1'b0);
    send_city(COORD_MAX, COORD_MAX, 1'b0);
    send_city(COORD_MIN, COORD_MAX, 1'b1);
    // repeated city, zero-length edges
    send_city(-5 * Q_ONE, 7 * Q_ONE, 1'b0);
    send_city(-5 * Q_ONE, 7 * Q_ONE, 1'b0);
    send_city(-5 * Q_ONE, 7 * Q_ONE, 1'b1);
    // sub-unit steps where truncation decides
    send_city('0, '0, 1'b0);
    send_city(32'd1, 32'd1, 1'b0);
    send_city(32'hffff_ffff, 32'hffff_ffff, 1'b1);
    send_city(32'hffff_ffff, 32'hffff_ffff, 1'b0);
    send_city(COORD_MIN, 32'hffff_ffff, 1'b1);
    wait_drained();
  endtask

  // saturation would take ~1e9 edges, so it stays out of reach of the stimulus
  task automatic test_random_tours(input int unsigned budget, input int unsigned idle_pct,
                                   input int unsigned stall_pct);
    int unsigned sent;
    int unsigned n;
    city_idle_pct = idle_pct;
    result_stall_pct = stall_pct;
    sent = 0;
    while (sent < budget) begin
      n = ($urandom_range(9) == 0) ? $urandom_range(7, 24) : $urandom_range(1, 6);
      for (int i = 0; i < n; i++) send_city(rand_coord(), rand_coord(), i == n - 1);
      sent += n;
    end
    wait_drained();
  endtask

  // receiver holds off so results back up and city words stall
  task automatic test_backpressure_fill();
    city_idle_pct = 0;
    result_stall_pct = 0;
    holds_requested++;
    for (int i = 0; i < 8; i++) send_city(rand_coord(), rand_coord(), 1'b1);
    for (int i = 0; i < 3; i++) send_city(rand_coord(), rand_coord(), i == 2);
    wait_drained();
    holds_requested++;
    for (int i = 0; i < 12; i++) send_city(rand_coord(), rand_coord(), i % 3 == 2);
    wait_drained();
  endtask

  // result sink: checks each word, then drives ready for the next edge
  initial begin : result_sink
    int unsigned  hold_left;
    int unsigned  holds_served;
    tour_result_t want;
    hold_left = 0;
    holds_served = 0;
    tour_bus.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (rst_n && tour_bus.valid && tour_bus.ready) begin
        if (pending_tours.size() == 0) begin
          $error("result word with nothing expected: tour_length %0d saturated %0b",
                 tour_bus.tour_length, tour_bus.saturated);
          errors++;
        end else begin
          want = pending_tours.pop_front();
          if (tour_bus.tour_length !== want.length) begin
            $error("tour_length: expected %0d, got %0d", want.length, tour_bus.tour_length);
            errors++;
          end
          if (tour_bus.saturated !== want.sat) begin
            $error("saturated: expected %0b, got %0b", want.sat, tour_bus.saturated);
            errors++;
          end
        end
      end
      if (holds_served != holds_requested) begin
        holds_served = holds_requested;
        hold_left = HOLD_CYCLES;
      end
      if (hold_left != 0) begin
        hold_left--;
        tour_bus.ready <= 1'b0;
      end else begin
        tour_bus.ready <= ($urandom_range(99) >= result_stall_pct);
      end
    end
  end

  int unsigned quiet_cycles = 0;

  always @(posedge clk) begin
    if (!rst_n || (city_bus.valid && city_bus.ready) || (tour_bus.valid && tour_bus.ready)) begin
      quiet_cycles = 0;
    end else begin
      quiet_cycles++;
      if (quiet_cycles == WATCHDOG_LIMIT) begin
        $display("Some tests failed");
        $finish;
      end
    end
  end

  initial begin
    clear_tour();
    rst_n = 1'b0;
    city_bus.valid     <= 1'b0;
    city_bus.x_coord   <= '0;
    city_bus.y_coord   <= '0;
    city_bus.last_city <= 1'b0;
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_directed();
    test_backpressure_fill();
    test_random_tours(460, 0, 0);
    test_random_tours(460, 76, 0);
    test_random_tours(460, 0, 76);
    test_random_tours(460, 32, 32);

    wait_drained();
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (errors == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule
